/* rtl/core/aes_block_cipher_defines.svh */
// Assertion macros shared by the AES cipher checker.
// No dependencies.
`ifndef AES_BLOCK_CIPHER_DEFINES_SVH
`define AES_BLOCK_CIPHER_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define AES_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define AES_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* rtl/core/aes_pkg.sv */
// Package for the AES cipher: S-box tables, GF(2^8) helpers, FSM state type,
// controller/datapath command and status structs. No dependencies.
`default_nettype none
package aes_pkg;

    localparam int unsigned MaxRkWords = 60;
    localparam int unsigned RkAw = 6;

    localparam logic [1:0] KS_128 = 2'd0;
    localparam logic [1:0] KS_192 = 2'd1;

    localparam logic [2:0] REG_KEY_SIZE = 3'd0;
    localparam logic [2:0] REG_KEY_W0   = 3'd1;
    localparam logic [2:0] REG_KEY_W3   = 3'd4;

    localparam logic CMD_ENCRYPT = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE, ST_KLOAD, ST_KEXP, ST_RK_FETCH, ST_ROUND, ST_DONE
    } t_state;

    typedef struct packed {
        logic       load_block;
        logic       kload;
        logic       kexp;
        logic       rk_fetch;
        logic       round;
        logic       emit;
        logic [5:0] word_idx;
        logic [3:0] round_idx;
        logic       first_round;
        logic       last_round;
    } t_cmd;

    typedef struct packed {
        logic       out_busy;
        logic [3:0] nr;
        logic [3:0] nk;
        logic       decrypt;
    } t_status;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
        };
        return t[a];
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
        };
        return t[a];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

endpackage
`default_nettype wire

/* rtl/core/aes_block_cipher.sv */
// AES block cipher top level: configuration registers, controller, datapath.
// Depends on aes_pkg, aes_ctrl, aes_dp.
//
//  channel | signals                                  | direction
//  cfg     | i_cfg_we, i_cfg_index, i_cfg_data         | in, no handshake back
//  in      | i_in_valid/o_in_ready, command, data      | in
//  out     | o_out_valid/i_out_ready, result           | out
//
// A result's timing after its input transfer is set by the round count (10, 12
// or 14 rounds) and by the single 32-bit round-key memory read port
// (one word per cycle); the next input transfer is accepted only after the
// result has been emitted and the controller is back in idle.
// The first block after a key write first loads the Nk key words and then
// expands the remaining schedule words, one schedule word per cycle.
// Reset is synchronous, active low; the round-key memory is not cleared.
// A result waits in the output register; the next block is held off while
// a block is in progress and while that register is full and not being taken.
`default_nettype none
module aes_block_cipher
    import aes_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_command,
    input  wire logic [63:0] i_data_high,
    input  wire logic [63:0] i_data_low,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [63:0]      o_result_high,
    output logic [63:0]      o_result_low
);

    logic [1:0]   r_key_size;
    logic [255:0] r_key;
    logic         sched_clear;
    t_cmd         cmd;
    t_status      status;

    // Any write to the key size or a key word register drops the stored schedule.
    assign sched_clear = i_cfg_we && (i_cfg_index <= REG_KEY_W3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_size <= KS_128;
            r_key <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_KEY_SIZE) r_key_size <= i_cfg_data[1:0];
            else if (i_cfg_index <= REG_KEY_W3)
                r_key[255 - 64*2'(i_cfg_index - REG_KEY_W0) -: 64] <= i_cfg_data;
        end
    end

    aes_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_sched_clear (sched_clear),
        .i_status      (status),
        .o_cmd         (cmd)
    );

    aes_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_key_size    (r_key_size),
        .i_key         (r_key),
        .i_command     (i_command),
        .i_data_high   (i_data_high),
        .i_data_low    (i_data_low),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_result_high (o_result_high),
        .o_result_low  (o_result_low),
        .o_status      (status)
    );

endmodule
`default_nettype wire

/* rtl/core/aes_ctrl.sv */
// Controller FSM for the AES cipher: key loading, key expansion, round sequencing.
// Depends on aes_pkg.
`default_nettype none
module aes_ctrl
    import aes_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire logic    i_sched_clear,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    t_state     r_state, n_state;
    logic [5:0] r_idx, n_idx;
    logic [3:0] r_round, n_round;
    logic       r_sched_ok, n_sched_ok;
    logic [5:0] total_words;

    assign total_words = 6'(({2'b0, i_status.nr} + 6'd1) << 2);

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_round    = r_round;
        n_sched_ok = r_sched_ok;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && !i_status.out_busy) begin
                    n_idx = '0;
                    n_state = r_sched_ok ? ST_RK_FETCH : ST_KLOAD;
                end
            end
            ST_KLOAD: begin
                n_idx = r_idx + 6'd1;
                if (r_idx == 6'(i_status.nk - 4'd1)) n_state = ST_KEXP;
            end
            ST_KEXP: begin
                n_idx = r_idx + 6'd1;
                if (r_idx == total_words - 6'd1) begin
                    n_state = ST_RK_FETCH;
                    n_sched_ok = 1'b1;
                end
            end
            ST_RK_FETCH: begin
                n_round = i_status.decrypt ? i_status.nr : 4'd0;
                n_idx = '0;
                n_state = ST_ROUND;
            end
            ST_ROUND: begin
                n_idx = r_idx + 6'd1;
                if (r_idx[1:0] == 2'd3) begin
                    if (i_status.decrypt ? (r_round == 4'd0) : (r_round == i_status.nr))
                        n_state = ST_DONE;
                    else
                        n_round = i_status.decrypt ? r_round - 4'd1 : r_round + 4'd1;
                end
            end
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
        if (i_sched_clear) n_sched_ok = 1'b0;
    end

    always_comb begin
        o_cmd = '0;
        o_in_ready = 1'b0;
        o_cmd.word_idx = r_idx;
        o_cmd.round_idx = r_round;
        o_cmd.first_round = i_status.decrypt ? (r_round == i_status.nr) : (r_round == 4'd0);
        o_cmd.last_round = i_status.decrypt ? (r_round == 4'd0) : (r_round == i_status.nr);
        case (r_state)
            ST_IDLE: begin
                o_in_ready = !i_status.out_busy;
                o_cmd.load_block = i_in_valid && !i_status.out_busy;
            end
            ST_KLOAD:    o_cmd.kload = 1'b1;
            ST_KEXP:     o_cmd.kexp = 1'b1;
            ST_RK_FETCH: o_cmd.rk_fetch = 1'b1;
            ST_ROUND:    o_cmd.round = 1'b1;
            ST_DONE:     o_cmd.emit = 1'b1;
            default:     o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx <= '0;
            r_round <= '0;
            r_sched_ok <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx <= n_idx;
            r_round <= n_round;
            r_sched_ok <= n_sched_ok;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/aes_dp.sv */
// Datapath for the AES cipher: key schedule memory, state register, round
// logic (one word of round key per cycle, one round per four round-key words), output register.
// Depends on aes_pkg.
`default_nettype none
module aes_dp
    import aes_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    input  wire logic [1:0]  i_key_size,
    input  wire logic [255:0] i_key,
    input  wire logic        i_command,
    input  wire logic [63:0] i_data_high,
    input  wire logic [63:0] i_data_low,
    input  wire logic        i_out_ready,
    output logic             o_out_valid,
    output logic [63:0]      o_result_high,
    output logic [63:0]      o_result_low,
    output t_status          o_status
);

    logic [31:0]  r_rk_mem [MaxRkWords];
    logic [31:0]  r_rd_data;
    logic [31:0]  r_prev;
    logic [31:0]  r_hist [8];
    logic [7:0]   r_rcon;
    logic [2:0]   r_kcnt;
    logic [127:0] r_state;
    logic [127:0] r_work;
    logic [95:0]  r_rk_acc;
    logic         r_decrypt;
    logic         r_out_valid;
    logic [127:0] r_out;

    logic [3:0]  nk;
    logic [3:0]  nr;
    logic [31:0] kword;
    logic [31:0] t_word, rot_sub, sub_only, new_word;
    logic [5:0]  wr_addr, rd_addr;
    logic        wr_en;
    logic [5:0]  rk_base;
    logic [127:0] round_key, next_state;

    assign nk = (i_key_size == KS_128) ? 4'd4 : (i_key_size == KS_192) ? 4'd6 : 4'd8;
    assign nr = nk + 4'd6;
    assign o_status = {r_out_valid && !i_out_ready, nr, nk, r_decrypt};

    assign kword = i_key[255 - 32*i_cmd.word_idx[2:0] -: 32];

    // Key expansion: history window of the last nk words in r_hist[0..nk-1]
    assign t_word   = r_prev;
    assign rot_sub  = {sbox(t_word[23:16]), sbox(t_word[15:8]), sbox(t_word[7:0]),
                       sbox(t_word[31:24])} ^ {r_rcon, 24'd0};
    assign sub_only = {sbox(t_word[31:24]), sbox(t_word[23:16]), sbox(t_word[15:8]),
                       sbox(t_word[7:0])};
    always_comb begin
        if (r_kcnt == 3'd0)
            new_word = r_hist[0] ^ rot_sub;
        else if (nk == 4'd8 && r_kcnt == 3'd4)
            new_word = r_hist[0] ^ sub_only;
        else
            new_word = r_hist[0] ^ t_word;
    end

    assign wr_en   = i_cmd.kload || (i_cmd.kexp && i_cmd.word_idx >= 6'(nk));
    assign wr_addr = i_cmd.word_idx;

    assign rk_base = {i_cmd.round_idx, 2'b00};
    always_comb begin
        if (i_cmd.rk_fetch)
            rd_addr = r_decrypt ? {nr, 2'b00} : 6'd0;
        else if (i_cmd.word_idx[1:0] == 2'd3)
            rd_addr = r_decrypt ? rk_base - 6'd4 : rk_base + 6'd4;
        else
            rd_addr = rk_base + 6'(i_cmd.word_idx[1:0]) + 6'd1;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_rk_mem[wr_addr] <= i_cmd.kload ? kword : new_word;
        r_rd_data <= r_rk_mem[rd_addr];
    end

    // Round logic on the full state
    function automatic logic [31:0] mix_col(input logic [31:0] c);
        logic [7:0] a0, a1, a2, a3;
        a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
        return {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
                a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
                a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
                xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
    endfunction

    function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
        logic [7:0] a [4];
        logic [7:0] x2 [4];
        logic [7:0] x4 [4];
        logic [7:0] x8 [4];
        logic [7:0] m9 [4];
        logic [7:0] mb [4];
        logic [7:0] md [4];
        logic [7:0] me [4];
        for (int k = 0; k < 4; k++) begin
            a[k]  = c[31 - 8*k -: 8];
            x2[k] = xtime(a[k]);
            x4[k] = xtime(x2[k]);
            x8[k] = xtime(x4[k]);
            m9[k] = x8[k] ^ a[k];
            mb[k] = x8[k] ^ x2[k] ^ a[k];
            md[k] = x8[k] ^ x4[k] ^ a[k];
            me[k] = x8[k] ^ x4[k] ^ x2[k];
        end
        return {me[0] ^ mb[1] ^ md[2] ^ m9[3],
                m9[0] ^ me[1] ^ mb[2] ^ md[3],
                md[0] ^ m9[1] ^ me[2] ^ mb[3],
                mb[0] ^ md[1] ^ m9[2] ^ me[3]};
    endfunction

    function automatic logic [127:0] fwd_round_of(input logic [127:0] st);
        logic [7:0] s [16];
        logic [127:0] o;
        for (int i = 0; i < 16; i++) s[i] = st[127 - 8*i -: 8];
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                o[127 - 8*(r + 4*c) -: 8] = sbox(s[r + 4*((c + r) % 4)]);
        return o;
    endfunction

    function automatic logic [127:0] inv_round_of(input logic [127:0] st);
        logic [7:0] s [16];
        logic [127:0] o;
        for (int i = 0; i < 16; i++) s[i] = st[127 - 8*i -: 8];
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                o[127 - 8*(r + 4*((c + r) % 4)) -: 8] = inv_sbox(s[r + 4*c]);
        return o;
    endfunction

    assign round_key = {r_rk_acc, r_rd_data};

    // Encrypt mixes before the key addition, decrypt after it
    always_comb begin
        logic [127:0] x;
        x = r_work ^ round_key;
        if (i_cmd.first_round || i_cmd.last_round)
            next_state = x;
        else if (!r_decrypt)
            next_state = {mix_col(r_work[127:96]), mix_col(r_work[95:64]),
                          mix_col(r_work[63:32]), mix_col(r_work[31:0])} ^ round_key;
        else
            next_state = {inv_mix_col(x[127:96]), inv_mix_col(x[95:64]),
                          inv_mix_col(x[63:32]), inv_mix_col(x[31:0])};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_block) begin
            r_state <= {i_data_high, i_data_low};
            r_decrypt <= (i_command != CMD_ENCRYPT);
        end
        if (i_cmd.rk_fetch) r_work <= r_state;
        if (i_cmd.round) begin
            r_rk_acc <= {r_rk_acc[63:0], r_rd_data};
            if (i_cmd.word_idx[1:0] == 2'd3) begin
                r_state <= next_state;
                // stage the substitution/shift for the following round
                r_work <= r_decrypt ? inv_round_of(next_state) : fwd_round_of(next_state);
            end
        end
        if (i_cmd.kload || i_cmd.kexp) begin
            if (i_cmd.kload || i_cmd.word_idx >= 6'(nk)) begin
                r_prev <= i_cmd.kload ? kword : new_word;
                for (int k = 0; k < 7; k++) r_hist[k] <= r_hist[k + 1];
                r_hist[3'(nk - 4'd1)] <= i_cmd.kload ? kword : new_word;
            end
            if (i_cmd.kload) begin
                r_kcnt <= '0;
                r_rcon <= 8'h01;
            end else if (i_cmd.word_idx >= 6'(nk)) begin
                if (r_kcnt == 3'(nk - 4'd1)) r_kcnt <= '0;
                else r_kcnt <= r_kcnt + 3'd1;
                if (r_kcnt == 3'd0) r_rcon <= xtime(r_rcon);
            end
        end
    end

    // Output register: hold the result until transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.emit) r_out <= r_state;
    end

    assign o_out_valid   = r_out_valid;
    assign o_result_high = r_out[127:64];
    assign o_result_low  = r_out[63:0];

endmodule
`default_nettype wire

/* rtl/core/aes_chk.sv */
// Port-level checker for the AES cipher, bound to the top level.
// Depends on aes_block_cipher_defines.svh.
`default_nettype none
`include "aes_block_cipher_defines.svh"
module aes_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [63:0] o_result_high
);
    `AES_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)
    `AES_ASSERT_NXT(a_res_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(o_result_high))
    `AES_ASSERT_NXT(a_no_quick, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_out_valid || $past(o_out_valid))
    `AES_ASSERT_NXT(a_busy, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
endmodule
bind aes_block_cipher aes_chk u_chk (.*);
`default_nettype wire
